>>> sv/b64u_pkg.sv
// Shared types, constants and the alphabet lookup for the URL-safe Base64 stream encoder.
`default_nettype none

package b64u_pkg;

  // Depth of the job queue between the byte front end and the character back end.
  localparam int unsigned QueueDepth = 2;

  // ASCII code of the padding character.
  localparam logic [6:0] PadChar = 7'd61;

  // One input word: a raw message byte and the end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  // One output word: an ASCII character and the end-of-message flag.
  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_word_t;

  // Position inside the current 3-byte group, one-hot.
  typedef enum logic [2:0] {
    PhaseFirst  = 3'b001,
    PhaseSecond = 3'b010,
    PhaseThird  = 3'b100
  } phase_e;

  // One classified byte: up to two sextets plus padding, ready to serialize.
  typedef struct packed {
    logic [5:0] sextet_a;
    logic [5:0] sextet_b;
    logic       use_b;       // Second sextet is emitted as a character.
    logic [1:0] last_index;  // Index of the final character of this job.
    logic       final_job;   // Job closes the message.
  } job_t;

  // Map a 6-bit value onto the URL-safe alphabet.
  function automatic logic [6:0] enc_sextet(input logic [5:0] v);
    logic [6:0] ch;
    ch = 7'd95;
    case (v) inside
      [6'd0:6'd25]:  ch = 7'({1'b0, v}) + 7'd65;
      [6'd26:6'd51]: ch = 7'({1'b0, v}) + 7'd71;
      [6'd52:6'd61]: ch = 7'({1'b0, v}) - 7'd4;
      6'd62:         ch = 7'd45;
      default:       ch = 7'd95;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> sv/b64u_front.sv
// Front end: accepts message bytes, tracks the group position and builds one job per byte.
`default_nettype none

module b64u_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire b64u_pkg::in_word_t in_word_i,
  input  wire logic               queue_full_i,
  output logic                    push_o,
  output b64u_pkg::job_t          job_o
);
  import b64u_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [7:0] b;
  logic       fin;

  assign b          = in_word_i.data_byte;
  assign fin        = in_word_i.final_byte;
  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Split the byte into sextets according to the group position.
  always_comb begin
    job_o.final_job = fin;
    phase_d         = phase_q;
    carry_d         = carry_q;
    case (phase_q)
      PhaseSecond: begin
        job_o.sextet_a   = {carry_q[1:0], b[7:4]};
        job_o.sextet_b   = {b[3:0], 2'b00};
        job_o.use_b      = fin;
        job_o.last_index = fin ? 2'd2 : 2'd0;
        phase_d          = fin ? PhaseFirst : PhaseThird;
        carry_d          = fin ? 4'd0 : b[3:0];
      end
      PhaseThird: begin
        job_o.sextet_a   = {carry_q, b[7:6]};
        job_o.sextet_b   = b[5:0];
        job_o.use_b      = 1'b1;
        job_o.last_index = 2'd1;
        phase_d          = PhaseFirst;
        carry_d          = 4'd0;
      end
      default: begin
        job_o.sextet_a   = b[7:2];
        job_o.sextet_b   = {b[1:0], 4'b0000};
        job_o.use_b      = fin;
        job_o.last_index = fin ? 2'd3 : 2'd0;
        phase_d          = fin ? PhaseFirst : PhaseSecond;
        carry_d          = fin ? 4'd0 : {2'b00, b[1:0]};
      end
    endcase
  end

  // Group position and leftover bits advance on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseFirst;
      carry_q <= 4'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/b64u_queue.sv
// Small job queue that decouples the byte front end from the character back end.
`default_nettype none

module b64u_queue #(
  parameter int unsigned Depth = b64u_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire b64u_pkg::job_t push_job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output b64u_pkg::job_t      head_o
);
  import b64u_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];

  // Storage is written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job popped from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

>>> sv/b64u_back.sv
// Back end: serializes each job into characters through a registered output stage.
`default_nettype none

module b64u_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  wire b64u_pkg::job_t job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output b64u_pkg::out_word_t out_word_o
);
  import b64u_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q;
  out_word_t  out_q, char_d;
  logic       load;

  // Load a new character whenever a job is waiting and the output register is empty or being drained.
  assign load  = job_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && (idx_q == job_i.last_index);

  // Pick sextet or padding for the current character of the job.
  always_comb begin
    if (idx_q == 2'd0) begin
      char_d.out_char = enc_sextet(job_i.sextet_a);
    end else if (idx_q == 2'd1 && job_i.use_b) begin
      char_d.out_char = enc_sextet(job_i.sextet_b);
    end else begin
      char_d.out_char = PadChar;
    end
    char_d.last_char = job_i.final_job && (idx_q == job_i.last_index);
    idx_d = pop_o ? 2'd0 : (load ? idx_q + 2'd1 : idx_q);
  end

  // Character index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= char_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q <= job_i.last_index)
    else $error("character index past the end of its job");

  a_mid_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> job_valid_i)
    else $error("job left the queue before all its characters were sent");

  a_last_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && char_d.last_char) |-> pop_o)
    else $error("message end flagged without retiring the job");

endmodule

`default_nettype wire

>>> sv/base64url_stream_encoder.sv
// Top level of the URL-safe Base64 stream encoder with padding.
//
//   Channel  | Direction | Handshake                | Word
//   ---------+-----------+--------------------------+-------------------------------
//   in       | input     | in_valid_i / in_ready_o  | in_word_i: data_byte, final_byte
//   out      | output    | out_valid_o / out_ready_i| out_word_o: out_char, last_char
//
// A byte is taken in every cycle while the job queue has room; each byte becomes
// one job of one to four characters, and the back end sends one character per cycle
// while out_ready_i is high. Throughput is set by the single output register;
// a byte yields one or two characters, or up to four on the final byte.
// Reset clears the group position, the queue and the output valid; no clearing pass.
// A stalled output fills the queue, after which in_ready_o drops until a job retires.
`default_nettype none

module base64url_stream_encoder #(
  parameter int unsigned QueueDepth = b64u_pkg::QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire b64u_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output b64u_pkg::out_word_t      out_word_o
);
  import b64u_pkg::*;

  logic push, full, pop, job_valid;
  job_t push_job, head_job;

  b64u_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  b64u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .head_o     (head_job)
  );

  b64u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
